// ===== design/assert_macros.svh =====
// Concurrent assertion macros shared by the scan-code block.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check prop at every rising edge except while rst is high.
`define KSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scan-code block check failed");
// Check prop at every rising edge, reset included.
`define KSA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("scan-code block check failed");
`else
`define KSA_ASSERT(label, clk, rst, prop)
`define KSA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/ksa_pkg.sv =====
// Types, scan-code constants and the ASCII translation tables.
// Depends on nothing; used by the decoder and the top level.
package ksa_pkg;

   localparam logic [7:0] BreakBit      = 8'h80;
   localparam logic [7:0] LshiftMake    = 8'h2A;
   localparam logic [7:0] RshiftMake    = 8'h36;
   localparam logic [7:0] LshiftBreak   = 8'hAA;
   localparam logic [7:0] RshiftBreak   = 8'hB6;
   localparam logic [7:0] BackspaceMake = 8'h0E;
   localparam int         TableLen      = 89;
   localparam int         CharWidth     = 7;

   typedef logic [CharWidth-1:0] char_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SHIFT_SET,
      OP_SHIFT_CLR,
      OP_BACKSPACE,
      OP_PUSH,
      OP_POP
   } op_code_type;

   typedef struct packed {
      op_code_type op;
      char_type    ch;
   } op_type;

   localparam char_type PlainTable [TableLen] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam char_type ShiftTable [TableLen] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // Translate a make code; codes past the end of the table give no character.
   function automatic char_type ascii_lookup(input logic shift, input logic [6:0] code);
      char_type ch;
      ch = '0;
      if (int'(code) < TableLen) begin
         ch = shift ? ShiftTable[code] : PlainTable[code];
      end
      return ch;
   endfunction

endpackage

// ===== design/ksa_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on ksa_pkg for the character type.
interface ksa_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] scan_code;

   modport source (output valid, output kind, output scan_code, input ready);
   modport sink   (input valid, input kind, input scan_code, output ready);
endinterface

interface ksa_rsp_if import ksa_pkg::*;;
   logic     valid;
   logic     ready;
   char_type char_out;
   logic     char_valid;
   logic     buffer_empty;
   logic     dropped;

   modport source (output valid, output char_out, output char_valid,
                   output buffer_empty, output dropped, input ready);
   modport sink   (input valid, input char_out, input char_valid,
                   input buffer_empty, input dropped, output ready);
endinterface

// ===== design/ksa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ksa_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read until the next read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ksa_decode.sv =====
// Classifies a request into a buffer operation and translates make codes.
// Depends on ksa_pkg for the op type, constants and ASCII tables.
module ksa_decode import ksa_pkg::*; (
   input  logic       kind,
   input  logic [7:0] scan_code,
   input  logic       shift_held,
   output op_type     op
);

   char_type ch;

   assign ch = ascii_lookup(shift_held, scan_code[6:0]);

   always_comb begin
      op.ch = ch;
      priority if (kind) begin
         op.op = OP_POP;
      end else if ((scan_code & BreakBit) != '0) begin
         // only shift releases matter among break codes
         op.op = (scan_code == LshiftBreak || scan_code == RshiftBreak)
                 ? OP_SHIFT_CLR : OP_NONE;
      end else if (scan_code == LshiftMake || scan_code == RshiftMake) begin
         op.op = OP_SHIFT_SET;
      end else if (scan_code == BackspaceMake) begin
         op.op = OP_BACKSPACE;
      end else if (ch != '0) begin
         op.op = OP_PUSH;
      end else begin
         op.op = OP_NONE;
      end
   end

endmodule

// ===== design/keyboard_scancode_to_ascii_fifo.sv =====
// Keyboard scan-code-set-1 front end with a character ring buffer. Each request
// transfer is either a scan code byte (kind 0) or a software read (kind 1), and
// each gives exactly one response transfer. Break codes are ignored apart from
// left/right shift release; shift make sets the shift flag; backspace drops the
// newest unread character; other make codes below 89 are translated to ASCII
// and a nonzero character is queued, or flagged as dropped when the buffer is
// full (it holds BUFFER_DEPTH - 1 characters). A read pops the oldest character
// or answers char_valid = 0 when the buffer is empty. Rate: one request per
// clock cycle while responses are taken; the pointers live in flip-flops and
// update in the cycle of the transfer, and the characters live in a RAM with
// a registered read, and each cycle does at most one RAM access. The RAM needs
// no clearing pass: only entries between the read and write pointers are ever
// read. Reset is synchronous, active high.
`include "assert_macros.svh"

module keyboard_scancode_to_ascii_fifo import ksa_pkg::*; #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic     clock,
   input  logic     reset,
   ksa_req_if.sink   req_ch,
   ksa_rsp_if.source rsp_ch
);

   localparam int AddrWidth = $clog2(BUFFER_DEPTH);
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(BUFFER_DEPTH - 1);

   op_type               op;
   logic                 accept;
   logic                 shift_ff, shift_in;
   logic [AddrWidth-1:0] rd_ptr_ff, rd_ptr_in, rd_next;
   logic [AddrWidth-1:0] wr_ptr_ff, wr_ptr_in, wr_next, wr_prev;
   logic                 empty, full;
   logic                 ram_we, ram_re;
   char_type             ram_rd_data;
   logic                 pop_hit, push_lost;

   // stage 1: RAM read in flight
   logic s1_valid_ff, s1_valid_in;
   logic s1_hit_ff, s1_empty_ff, s1_lost_ff;
   // stage 2: response register
   logic     out_valid_ff, out_valid_in;
   char_type out_char_ff;
   logic     out_hit_ff, out_empty_ff, out_lost_ff;
   logic     out_free, s1_adv;

   ksa_decode u_decode (
      .kind       (req_ch.kind),
      .scan_code  (req_ch.scan_code),
      .shift_held (shift_ff),
      .op         (op)
   );

   // wrap at BUFFER_DEPTH, which need not be a power of two
   assign rd_next = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrWidth'(1);
   assign wr_next = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrWidth'(1);
   assign wr_prev = (wr_ptr_ff == '0) ? LastAddr : wr_ptr_ff - AddrWidth'(1);
   assign empty   = (rd_ptr_ff == wr_ptr_ff);
   assign full    = (wr_next == rd_ptr_ff);

   // advance when the response register is free or being drained
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      shift_in  = shift_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      pop_hit   = 1'b0;
      push_lost = 1'b0;
      if (accept) begin
         unique case (op.op)
            OP_POP: begin
               if (!empty) begin
                  ram_re    = 1'b1;
                  pop_hit   = 1'b1;
                  rd_ptr_in = rd_next;
               end
            end
            OP_PUSH: begin
               if (full) begin
                  push_lost = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  wr_ptr_in = wr_next;
               end
            end
            OP_BACKSPACE: begin
               if (!empty) begin
                  wr_ptr_in = wr_prev;
               end
            end
            OP_SHIFT_SET: shift_in = 1'b1;
            OP_SHIFT_CLR: shift_in = 1'b0;
            OP_NONE:      ;
            default:      ;
         endcase
      end
   end

   // A pop never shares a cycle with a push, and a push lands in the RAM at the
   // edge before any later pop reads it, so no bypass of the store is needed.
   ksa_ram #(
      .WIDTH (CharWidth),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (op.ch),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: capture flags on transfer, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff   <= pop_hit;
         s1_empty_ff <= (rd_ptr_in == wr_ptr_in);
         s1_lost_ff  <= push_lost;
      end
      if (s1_adv) begin
         out_char_ff  <= s1_hit_ff ? ram_rd_data : '0;
         out_hit_ff   <= s1_hit_ff;
         out_empty_ff <= s1_empty_ff;
         out_lost_ff  <= s1_lost_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.char_out     = out_char_ff;
   assign rsp_ch.char_valid   = out_hit_ff;
   assign rsp_ch.buffer_empty = out_empty_ff;
   assign rsp_ch.dropped      = out_lost_ff;

   // a popped character was queued, so it is never zero
   `KSA_ASSERT(a_pop_nonzero, clock, reset, out_valid_ff && out_hit_ff |-> out_char_ff != '0)
   // a stalled read must keep its data until it moves to the response register
   `KSA_ASSERT(a_read_held, clock, reset, s1_valid_ff && !out_free |=> $stable(ram_rd_data))
   // one request per cycle: never a read and a write of the store together
   `KSA_ASSERT_ALWAYS(a_one_access, clock, !(ram_we && ram_re))
   // a response never both returns and drops a character
   `KSA_ASSERT(a_hit_or_lost, clock, reset, out_valid_ff |-> !(out_hit_ff && out_lost_ff))

endmodule
